### sv/plsu_pkg.sv
// ----------------------------------------------------------------------------
// plsu_pkg
// Shared types and constants of the positional list store: action and
// status codes, controller states and the control word sent along the cells.
// ----------------------------------------------------------------------------
package plsu_pkg;

  // default number of list cells
  localparam int unsigned CAPACITY_DEF = 32;

  // fixed field widths of the transactions
  localparam int unsigned POS_W   = 7;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 6;

  // action carried in the input tuser
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_LIST   = 2'd3
  } action_t;

  // status carried in the output tuser
  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_BADPOS = 3'd1,
    STAT_EMPTY  = 3'd2,
    STAT_RANGE  = 3'd3,
    STAT_FULL   = 3'd4
  } status_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LIST = 1'b1
  } state_t;

  // per-cycle operation of the cell row
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_DELETE = 3'd2,
    CELL_WRITE  = 3'd3,
    CELL_ROTATE = 3'd4
  } cell_op_t;

  // control word broadcast to every cell
  typedef struct packed {
    cell_op_t            op;
    logic [POS_W-1:0]    idx;       // zero-based target slot
    logic [POS_W-1:0]    last_idx;  // slot of the last element, for rotation
    logic [DATA_W-1:0]   data;      // value to insert or write
  } cell_ctl_t;

endpackage

### sv/positional_list_store_unit.sv
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Ordered list of signed 32-bit values addressed by 1-based position, built
// as a row of shifting cells with a controller and a registered output.
// ----------------------------------------------------------------------------
// Insert, delete and update shift or write the whole cell row at once, so
// such a transaction can be accepted every cycle while the output register
// is free or being drained. Listing an empty list gives a single result as
// well. Listing a non-empty list holds the input: the transaction is first
// accepted, then for each element the row rotates by one slot and the head
// cell is loaded into the output register; output stalls stretch the walk,
// and no input transaction is accepted until the last element has been
// loaded. Every failed operation and the listing of an empty list give one
// result with last set. Slot contents are not cleared at reset and no
// clearing pass runs; only slots below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_store_unit #(
  parameter int unsigned CAPACITY = plsu_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [6:0] position, [38:7] value, [39] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] element, [37:32] count, [39:38] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast
);

  localparam int unsigned DW = plsu_pkg::DATA_W;
  localparam int unsigned PW = plsu_pkg::POS_W;
  localparam int unsigned CW = plsu_pkg::COUNT_W;

  plsu_pkg::cell_ctl_t cell_ctl;
  plsu_pkg::status_t   out_status;
  logic [DW-1:0]       out_element;
  logic [CW-1:0]       out_count;
  logic [DW-1:0]       cell_q [CAPACITY];

  // controller
  plsu_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_action   (plsu_pkg::action_t'(in_tuser)),
    .in_position (in_tdata[PW-1:0]),
    .in_value    (in_tdata[PW+DW-1:PW]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_status),
    .out_element (out_element),
    .out_last    (out_tlast),
    .out_count   (out_count),
    .head_i      (cell_q[0]),
    .cell_ctl_o  (cell_ctl)
  );

  // row of list cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_d;
    logic [DW-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    plsu_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk     (clk),
      .ctl_i   (cell_ctl),
      .left_i  (left_d),
      .right_i (right_d),
      .head_i  (cell_q[0]),
      .data_o  (cell_q[i])
    );
  end

  // result packing
  assign out_tdata = {2'b00, out_count, out_element};
  assign out_tuser = out_status;

endmodule

### sv/plsu_cell.sv
// ----------------------------------------------------------------------------
// plsu_cell
// One slot of the list. Holds a value and, by the broadcast control word,
// keeps it, loads new data, or takes its left, right or head neighbor.
// ----------------------------------------------------------------------------
module plsu_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                             clk,
  input  plsu_pkg::cell_ctl_t              ctl_i,
  input  logic [plsu_pkg::DATA_W-1:0]      left_i,
  input  logic [plsu_pkg::DATA_W-1:0]      right_i,
  input  logic [plsu_pkg::DATA_W-1:0]      head_i,
  output logic [plsu_pkg::DATA_W-1:0]      data_o
);

  localparam int unsigned PW = plsu_pkg::POS_W;
  localparam logic [PW-1:0] MY_IDX = PW'(CELL_IDX);

  logic [plsu_pkg::DATA_W-1:0] data_r;
  logic [plsu_pkg::DATA_W-1:0] data_nxt;

  // slot update by operation
  always_comb begin
    data_nxt = data_r;
    unique case (ctl_i.op)
      plsu_pkg::CELL_INSERT: begin
        if (MY_IDX > ctl_i.idx) begin
          data_nxt = left_i;
        end else if (MY_IDX == ctl_i.idx) begin
          data_nxt = ctl_i.data;
        end
      end
      plsu_pkg::CELL_DELETE: begin
        if (MY_IDX >= ctl_i.idx) begin
          data_nxt = right_i;
        end
      end
      plsu_pkg::CELL_WRITE: begin
        if (MY_IDX == ctl_i.idx) begin
          data_nxt = ctl_i.data;
        end
      end
      plsu_pkg::CELL_ROTATE: begin
        if (MY_IDX < ctl_i.last_idx) begin
          data_nxt = right_i;
        end else if (MY_IDX == ctl_i.last_idx) begin
          data_nxt = head_i;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

### sv/plsu_ctrl.sv
// ----------------------------------------------------------------------------
// plsu_ctrl
// Controller of the list store: checks positions, keeps the element count,
// drives the cell row and owns the output register. A list walk rotates the
// row once per element and emits the head cell each cycle the output is free.
// ----------------------------------------------------------------------------
module plsu_ctrl #(
  parameter int unsigned CAPACITY = plsu_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input transaction
  input  logic                              in_valid,
  output logic                              in_ready,
  input  plsu_pkg::action_t                 in_action,
  input  logic [plsu_pkg::POS_W-1:0]        in_position,
  input  logic [plsu_pkg::DATA_W-1:0]       in_value,
  // result transaction
  output logic                              out_valid,
  input  logic                              out_ready,
  output plsu_pkg::status_t                 out_status,
  output logic [plsu_pkg::DATA_W-1:0]       out_element,
  output logic                              out_last,
  output logic [plsu_pkg::COUNT_W-1:0]      out_count,
  // cell row
  input  logic [plsu_pkg::DATA_W-1:0]       head_i,
  output plsu_pkg::cell_ctl_t               cell_ctl_o
);

  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  localparam int unsigned PW    = plsu_pkg::POS_W;
  localparam int unsigned CW    = plsu_pkg::COUNT_W;
  localparam int unsigned DW    = plsu_pkg::DATA_W;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CAPACITY);

  plsu_pkg::state_t   state_r, state_nxt;
  logic [LEN_W-1:0]   length_r, length_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  plsu_pkg::status_t  out_status_r, out_status_nxt;
  logic [DW-1:0]      out_element_r, out_element_nxt;
  logic               out_last_r, out_last_nxt;
  logic [CW-1:0]      out_count_r, out_count_nxt;

  logic               out_free;
  logic               accept;
  logic               list_last;
  logic [LEN_W-1:0]   len_m1;
  logic [PW:0]        pos_x;
  logic [PW:0]        len_x;
  plsu_pkg::status_t  chk_status;
  plsu_pkg::cell_op_t chk_op;
  logic [LEN_W-1:0]   chk_len;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == plsu_pkg::ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign len_m1    = length_r - LEN_W'(1);
  assign list_last = (cnt_r == len_m1);
  assign pos_x     = {1'b0, in_position};
  assign len_x     = (PW + 1)'(length_r);

  // position and capacity checks of an incoming transaction
  always_comb begin
    chk_status = plsu_pkg::STAT_OK;
    chk_op     = plsu_pkg::CELL_HOLD;
    chk_len    = length_r;
    priority if (in_action == plsu_pkg::ACT_LIST) begin
      chk_status = (length_r == '0) ? plsu_pkg::STAT_EMPTY : plsu_pkg::STAT_OK;
    end else if (in_position == '0) begin
      chk_status = plsu_pkg::STAT_BADPOS;
    end else if (in_action == plsu_pkg::ACT_INSERT) begin
      priority if (pos_x > len_x + (PW + 1)'(1)) begin
        chk_status = plsu_pkg::STAT_RANGE;
      end else if (length_r >= LEN_MAX) begin
        chk_status = plsu_pkg::STAT_FULL;
      end else begin
        chk_op  = plsu_pkg::CELL_INSERT;
        chk_len = length_r + LEN_W'(1);
      end
    end else if (length_r == '0) begin
      chk_status = plsu_pkg::STAT_EMPTY;
    end else if (pos_x > len_x) begin
      chk_status = plsu_pkg::STAT_RANGE;
    end else if (in_action == plsu_pkg::ACT_DELETE) begin
      chk_op  = plsu_pkg::CELL_DELETE;
      chk_len = len_m1;
    end else begin
      chk_op = plsu_pkg::CELL_WRITE;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plsu_pkg::ST_IDLE: begin
        if (accept && in_action == plsu_pkg::ACT_LIST && length_r != '0) begin
          state_nxt = plsu_pkg::ST_LIST;
        end
      end
      plsu_pkg::ST_LIST: begin
        if (out_free && list_last) begin
          state_nxt = plsu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = plsu_pkg::ST_IDLE;
    endcase
  end

  // outputs: cell control, count, counter and output register loads
  always_comb begin
    cell_ctl_o.op       = plsu_pkg::CELL_HOLD;
    cell_ctl_o.idx      = in_position - PW'(1);
    cell_ctl_o.last_idx = PW'(len_m1);
    cell_ctl_o.data     = in_value;
    length_nxt          = length_r;
    cnt_nxt             = cnt_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_status_nxt      = out_status_r;
    out_element_nxt     = out_element_r;
    out_last_nxt        = out_last_r;
    out_count_nxt       = out_count_r;
    unique case (state_r)
      plsu_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if (!(in_action == plsu_pkg::ACT_LIST && length_r != '0)) begin
            // single result transaction
            cell_ctl_o.op   = chk_op;
            length_nxt      = chk_len;
            out_valid_nxt   = 1'b1;
            out_status_nxt  = chk_status;
            out_element_nxt = '0;
            out_last_nxt    = 1'b1;
            out_count_nxt   = CW'(chk_len);
          end
        end
      end
      plsu_pkg::ST_LIST: begin
        if (out_free) begin
          // emit the head cell and rotate the row by one
          cell_ctl_o.op   = plsu_pkg::CELL_ROTATE;
          cnt_nxt         = cnt_r + LEN_W'(1);
          out_valid_nxt   = 1'b1;
          out_status_nxt  = plsu_pkg::STAT_OK;
          out_element_nxt = head_i;
          out_last_nxt    = list_last;
          out_count_nxt   = CW'(length_r);
        end
      end
      default: cell_ctl_o.op = plsu_pkg::CELL_HOLD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plsu_pkg::ST_IDLE;
      length_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      length_r    <= length_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;
  assign out_count   = out_count_r;

  // count never exceeds the number of cells
  assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= LEN_MAX)
    else $error("element count above capacity");

  // no input is taken during a list walk
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == plsu_pkg::ST_LIST |-> !in_ready)
    else $error("input accepted while listing");

  // the walk index stays inside the list
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == plsu_pkg::ST_LIST |-> cnt_r < length_r && length_r != '0)
    else $error("list walk index out of range");

  // a successful insert grows the list by one
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && chk_op == plsu_pkg::CELL_INSERT |=> length_r == $past(length_r) + LEN_W'(1))
    else $error("insert did not grow the list");

  // the count only changes on an accepted transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(length_r))
    else $error("count changed without a transaction");

endmodule
